>>> sv/http_header_byte_parser_macros.svh
// Assertion macros for the HTTP header byte parser.
// Used by the top level; expects clk and rst_n in scope.
`ifndef HTTP_HEADER_BYTE_PARSER_MACROS_SVH
`define HTTP_HEADER_BYTE_PARSER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HHP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define HHP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/hhp_pkg.sv
// Shared types and constants for the HTTP header byte parser.
// No dependencies.
`timescale 1ns / 1ps

package hhp_pkg;

    localparam int BYTE_W  = 8;
    localparam int ROLE_W  = 4;
    localparam int CAUSE_W = 3;
    localparam int LEN_W   = 11;

    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

    localparam logic [LEN_W-1:0] MAX_VALUE_LEN_RST = 11'd256;

    typedef enum logic [3:0] {
        ST_START     = 4'd0,
        ST_KEY       = 4'd1,
        ST_COLON     = 4'd2,
        ST_SPACE     = 4'd3,
        ST_VALUE     = 4'd4,
        ST_CR        = 4'd5,
        ST_LF        = 4'd6,
        ST_ENDCR     = 4'd7,
        ST_DONE      = 4'd8,
        ST_ERR_KEY   = 4'd9,
        ST_ERR_SPACE = 4'd10,
        ST_ERR_LONG  = 4'd11,
        ST_ERR_CR    = 4'd12,
        ST_ERR_ENDCR = 4'd13
    } hhp_state_t;

    typedef enum logic [ROLE_W-1:0] {
        ROLE_SKIP  = 4'd0,
        ROLE_KEY   = 4'd1,
        ROLE_COLON = 4'd2,
        ROLE_SPACE = 4'd3,
        ROLE_VALUE = 4'd4,
        ROLE_VCR   = 4'd5,
        ROLE_LLF   = 4'd6,
        ROLE_ECR   = 4'd7,
        ROLE_DONE  = 4'd8,
        ROLE_BODY  = 4'd9,
        ROLE_ERR   = 4'd10,
        ROLE_AFTER = 4'd11
    } hhp_role_t;

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_NONE      = 3'd0,
        CAUSE_KEY_CRLF  = 3'd1,
        CAUSE_NO_SPACE  = 3'd2,
        CAUSE_TOO_LONG  = 3'd3,
        CAUSE_CR_NO_LF  = 3'd4,
        CAUSE_END_NO_LF = 3'd5
    } hhp_cause_t;

    // Register word index on the APB port
    localparam logic REG_MAX_VALUE_LEN = 1'b0;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              restart;
    } hhp_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        hhp_role_t         role;
        hhp_cause_t        error_cause;
        logic [LEN_W-1:0]  value_length;
    } hhp_result_t;

endpackage

>>> sv/http_header_byte_parser.sv
// HTTP header byte parser: takes one byte of a header block per clock while
// in_ready is high and returns it with a role tag (skip, key, colon, space,
// value, CR, LF, end, body, error, after-error), an error cause and the
// running value length. Throughput is one byte per clock when the output
// does not stall. A byte passes through the input register and then the
// result register, where its result is held until it is taken. A stalled
// output backs up through both registers before in_ready drops. The parser
// state and value counter are fed back to their own registers through the
// parse step. max_value_len is set over the APB port at word 0
// and should only be written while no transaction is in flight.
`timescale 1ns / 1ps

module http_header_byte_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [hhp_pkg::BYTE_W-1:0] data_byte,
    input  logic                       restart,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [hhp_pkg::BYTE_W-1:0] out_byte,
    output logic [hhp_pkg::ROLE_W-1:0] role,
    output logic [hhp_pkg::CAUSE_W-1:0] error_cause,
    output logic [hhp_pkg::LEN_W-1:0]  value_length
);
    import hhp_pkg::*;

    `include "http_header_byte_parser_macros.svh"

    logic             s1_valid_reg;
    logic             s1_valid_next;
    hhp_item_t        s1_item_reg;
    hhp_item_t        s1_item_next;
    logic             stage_ready;
    logic             in_fire;
    logic             s1_fire;
    logic [LEN_W-1:0] max_value_len;
    hhp_result_t      result;

    hhp_apb_regs u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .max_value_len (max_value_len)
    );

    // Input register
    assign s1_fire  = s1_valid_reg && stage_ready;
    assign in_ready = !s1_valid_reg || stage_ready;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        s1_item_next  = s1_item_reg;
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_item_next.data_byte = data_byte;
            s1_item_next.restart   = restart;
            s1_valid_next          = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
    end

    hhp_parse_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (s1_valid_reg),
        .item          (s1_item_reg),
        .stage_ready   (stage_ready),
        .max_value_len (max_value_len),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result        (result)
    );

    assign out_byte     = result.out_byte;
    assign role         = result.role;
    assign error_cause  = result.error_cause;
    assign value_length = result.value_length;

    `HHP_ASSERT_IMP(a_cause_only_on_error, out_valid && (error_cause != CAUSE_NONE), (role == ROLE_ERR) || (role == ROLE_AFTER), "error cause set on a non-error role")
    `HHP_ASSERT_IMP(a_after_has_cause, out_valid && (role == ROLE_AFTER), error_cause != CAUSE_NONE, "after-error role without cause")
    `HHP_ASSERT_IMP(a_stall_means_full, !in_ready, s1_valid_reg && out_valid && !out_ready, "input stalled with room in the pipe")
    `HHP_ASSERT_NXT(a_stage_to_output, s1_fire, out_valid, "processed byte did not reach output register")

endmodule

>>> sv/hhp_apb_regs.sv
// APB configuration register block for the HTTP header byte parser.
// Depends on hhp_pkg.
`timescale 1ns / 1ps

module hhp_apb_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output logic [hhp_pkg::LEN_W-1:0]  max_value_len
);
    import hhp_pkg::*;

    logic [LEN_W-1:0] max_len_reg;
    logic [LEN_W-1:0] max_len_next;
    logic             wr_en;

    assign wr_en = psel && penable && pwrite && (paddr[2] == REG_MAX_VALUE_LEN);

    always_comb
    begin
        max_len_next = max_len_reg;
        if (wr_en)
        begin
            max_len_next = pwdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_VALUE_LEN_RST;
        end
        else
        begin
            max_len_reg <= max_len_next;
        end
    end

    assign prdata        = (paddr[2] == REG_MAX_VALUE_LEN) ? {{(32-LEN_W){1'b0}}, max_len_reg}
                                                           : 32'd0;
    assign pready        = 1'b1;
    assign max_value_len = max_len_reg;

endmodule

>>> sv/hhp_parse_core.sv
// Parser state machine, value counter and result register.
// Depends on hhp_pkg.
`timescale 1ns / 1ps

module hhp_parse_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    input  hhp_pkg::hhp_item_t         item,
    output logic                       stage_ready,
    input  logic [hhp_pkg::LEN_W-1:0]  max_value_len,
    output logic                       out_valid,
    input  logic                       out_ready,
    output hhp_pkg::hhp_result_t       result
);
    import hhp_pkg::*;

    hhp_state_t       state_reg;
    hhp_state_t       state_next;
    logic [LEN_W-1:0] count_reg;
    logic [LEN_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    hhp_result_t      result_reg;
    hhp_result_t      result_next;

    hhp_state_t       cur_state;
    logic [LEN_W-1:0] cur_count;
    logic [LEN_W:0]   count_inc;
    hhp_role_t        role;
    hhp_cause_t       cause;
    logic [BYTE_W-1:0] b;
    logic             fire;

    assign stage_ready = !out_valid_reg || out_ready;
    assign fire        = item_valid && stage_ready;
    assign b           = item.data_byte;

    // Restart takes effect before the byte is looked at
    assign cur_state = item.restart ? ST_START : state_reg;
    assign cur_count = item.restart ? '0 : count_reg;
    assign count_inc = {1'b0, cur_count} + {{LEN_W{1'b0}}, 1'b1};

    always_comb
    begin
        state_next = cur_state;
        count_next = cur_count;
        role       = ROLE_SKIP;
        case (cur_state)
            ST_ERR_KEY, ST_ERR_SPACE, ST_ERR_LONG, ST_ERR_CR, ST_ERR_ENDCR:
            begin
                role = ROLE_AFTER;
            end
            ST_KEY:
            begin
                if (b == CH_COLON)
                begin
                    state_next = ST_COLON;
                    role       = ROLE_COLON;
                end
                else if (b == CH_CR || b == CH_LF)
                begin
                    state_next = ST_ERR_KEY;
                    role       = ROLE_ERR;
                end
                else
                begin
                    role = ROLE_KEY;
                end
            end
            ST_COLON:
            begin
                if (b == CH_SPACE)
                begin
                    state_next = ST_SPACE;
                    role       = ROLE_SPACE;
                end
                else
                begin
                    state_next = ST_ERR_SPACE;
                    role       = ROLE_ERR;
                end
            end
            ST_SPACE:
            begin
                // first value byte is taken unchecked, CR included
                state_next = ST_VALUE;
                count_next = {{(LEN_W-1){1'b0}}, 1'b1};
                role       = ROLE_VALUE;
            end
            ST_VALUE:
            begin
                if (b == CH_CR)
                begin
                    state_next = ST_CR;
                    role       = ROLE_VCR;
                end
                else if (count_inc > {1'b0, max_value_len})
                begin
                    state_next = ST_ERR_LONG;
                    role       = ROLE_ERR;
                end
                else
                begin
                    count_next = count_inc[LEN_W-1:0];
                    role       = ROLE_VALUE;
                end
            end
            ST_CR:
            begin
                if (b == CH_LF)
                begin
                    state_next = ST_LF;
                    role       = ROLE_LLF;
                end
                else
                begin
                    state_next = ST_ERR_CR;
                    role       = ROLE_ERR;
                end
            end
            ST_LF:
            begin
                if (b == CH_CR)
                begin
                    state_next = ST_ENDCR;
                    role       = ROLE_ECR;
                end
                else
                begin
                    state_next = ST_KEY;
                    count_next = '0;
                    role       = ROLE_KEY;
                end
            end
            ST_ENDCR:
            begin
                if (b == CH_LF)
                begin
                    state_next = ST_DONE;
                    role       = ROLE_DONE;
                end
                else
                begin
                    state_next = ST_ERR_ENDCR;
                    role       = ROLE_ERR;
                end
            end
            ST_DONE:
            begin
                role = ROLE_BODY;
            end
            default:
            begin
                // start state; leading CR/LF are skipped
                if (b == CH_CR || b == CH_LF)
                begin
                    state_next = ST_START;
                    role       = ROLE_SKIP;
                end
                else
                begin
                    state_next = ST_KEY;
                    count_next = '0;
                    role       = ROLE_KEY;
                end
            end
        endcase

        case (state_next)
            ST_ERR_KEY:   cause = CAUSE_KEY_CRLF;
            ST_ERR_SPACE: cause = CAUSE_NO_SPACE;
            ST_ERR_LONG:  cause = CAUSE_TOO_LONG;
            ST_ERR_CR:    cause = CAUSE_CR_NO_LF;
            ST_ERR_ENDCR: cause = CAUSE_END_NO_LF;
            default:      cause = CAUSE_NONE;
        endcase
    end

    always_comb
    begin
        result_next                = result_reg;
        out_valid_next             = out_valid_reg;
        if (fire)
        begin
            result_next.out_byte     = b;
            result_next.role         = role;
            result_next.error_cause  = cause;
            result_next.value_length = count_next;
            out_valid_next           = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_START;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                state_reg <= state_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

>>> tb/tb_http_header_byte_parser.sv
// Testbench for http_header_byte_parser: directed and random header byte streams,
// checked against an in-bench parse predictor. Depends on hhp_pkg and the block RTL.
`timescale 1ns / 1ps

module tb_http_header_byte_parser;

    import hhp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [BYTE_W-1:0]   data_byte = '0;
    logic                restart = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [BYTE_W-1:0]   out_byte;
    logic [ROLE_W-1:0]   role;
    logic [CAUSE_W-1:0]  error_cause;
    logic [LEN_W-1:0]    value_length;

    hhp_item_t   byte_q[$];
    hhp_result_t tag_q[$];

    // predictor state and its copy of the register
    hhp_state_t       p_state = ST_START;
    logic [LEN_W-1:0] p_count = '0;
    logic [LEN_W-1:0] cfg_len = MAX_VALUE_LEN_RST;

    int   snd_pct = 0;
    int   rcv_pct = 0;
    int   hold_req = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   err_cnt = 0;
    int   pushed = 0;
    int   cycle_cnt = 0;
    logic in_taken = 1'b0;

    http_header_byte_parser u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .role         (role),
        .error_cause  (error_cause),
        .value_length (value_length)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        err_cnt++;
        $display("ERROR @%0t: %s", $time, what);
    endtask

    // Tag one byte and advance the predicted parse state.
    function automatic hhp_result_t parse_byte(input hhp_item_t it);
        hhp_result_t r;
        logic [BYTE_W-1:0] b;
        b = it.data_byte;
        r.role = ROLE_SKIP;
        if (it.restart)
        begin
            p_state = ST_START;
            p_count = '0;
        end
        if (p_state >= ST_ERR_KEY && p_state <= ST_ERR_ENDCR)
        begin
            r.role = ROLE_AFTER;
        end
        else
        begin
            case (p_state)
                ST_KEY:
                begin
                    if (b == CH_COLON)
                    begin
                        p_state = ST_COLON;
                        r.role = ROLE_COLON;
                    end
                    else if (b == CH_CR || b == CH_LF)
                    begin
                        p_state = ST_ERR_KEY;
                        r.role = ROLE_ERR;
                    end
                    else
                    begin
                        r.role = ROLE_KEY;
                    end
                end
                ST_COLON:
                begin
                    if (b == CH_SPACE)
                    begin
                        p_state = ST_SPACE;
                        r.role = ROLE_SPACE;
                    end
                    else
                    begin
                        p_state = ST_ERR_SPACE;
                        r.role = ROLE_ERR;
                    end
                end
                ST_SPACE:
                begin
                    // first value byte is taken as is, CR too, with no length check
                    p_state = ST_VALUE;
                    p_count = {{(LEN_W-1){1'b0}}, 1'b1};
                    r.role = ROLE_VALUE;
                end
                ST_VALUE:
                begin
                    if (b == CH_CR)
                    begin
                        p_state = ST_CR;
                        r.role = ROLE_VCR;
                    end
                    else if (int'(p_count) + 1 > int'(cfg_len))
                    begin
                        p_state = ST_ERR_LONG;
                        r.role = ROLE_ERR;
                    end
                    else
                    begin
                        p_count = p_count + 1'b1;
                        r.role = ROLE_VALUE;
                    end
                end
                ST_CR:
                begin
                    if (b == CH_LF)
                    begin
                        p_state = ST_LF;
                        r.role = ROLE_LLF;
                    end
                    else
                    begin
                        p_state = ST_ERR_CR;
                        r.role = ROLE_ERR;
                    end
                end
                ST_LF:
                begin
                    if (b == CH_CR)
                    begin
                        p_state = ST_ENDCR;
                        r.role = ROLE_ECR;
                    end
                    else
                    begin
                        p_state = ST_KEY;
                        p_count = '0;
                        r.role = ROLE_KEY;
                    end
                end
                ST_ENDCR:
                begin
                    if (b == CH_LF)
                    begin
                        p_state = ST_DONE;
                        r.role = ROLE_DONE;
                    end
                    else
                    begin
                        p_state = ST_ERR_ENDCR;
                        r.role = ROLE_ERR;
                    end
                end
                ST_DONE:
                begin
                    r.role = ROLE_BODY;
                end
                default:
                begin
                    if (b == CH_CR || b == CH_LF)
                    begin
                        p_state = ST_START;
                        r.role = ROLE_SKIP;
                    end
                    else
                    begin
                        p_state = ST_KEY;
                        p_count = '0;
                        r.role = ROLE_KEY;
                    end
                end
            endcase
        end
        case (p_state)
            ST_ERR_KEY:   r.error_cause = CAUSE_KEY_CRLF;
            ST_ERR_SPACE: r.error_cause = CAUSE_NO_SPACE;
            ST_ERR_LONG:  r.error_cause = CAUSE_TOO_LONG;
            ST_ERR_CR:    r.error_cause = CAUSE_CR_NO_LF;
            ST_ERR_ENDCR: r.error_cause = CAUSE_END_NO_LF;
            default:      r.error_cause = CAUSE_NONE;
        endcase
        r.out_byte = b;
        r.value_length = p_count;
        return r;
    endfunction

    function automatic void push_item(input logic [BYTE_W-1:0] b, input logic rs);
        hhp_item_t it;
        it.data_byte = b;
        it.restart = rs;
        byte_q.push_back(it);
        pushed++;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_special();
        logic [BYTE_W-1:0] v;
        v = BYTE_W'($urandom_range(255));
        case ($urandom_range(5))
            0: v = CH_CR;
            1: v = CH_LF;
            2: v = CH_COLON;
            3: v = CH_SPACE;
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [BYTE_W-1:0] value_byte();
        logic [BYTE_W-1:0] v;
        v = BYTE_W'($urandom_range(255));
        if (v == CH_CR)
            v = 8'h76;
        return v;
    endfunction

    // One header block: 0..2 leading CR/LF, 1..4 lines, empty line, 0..3 body bytes.
    function automatic void gen_message(input bit corrupt);
        int start;
        int eff;
        int vlen;
        int sel;
        int idx;
        logic [BYTE_W-1:0] k;
        hhp_item_t tmp;
        start = byte_q.size();
        eff = (cfg_len == 0) ? 1 : int'(cfg_len);
        repeat ($urandom_range(2))
            push_item($urandom_range(1) ? CH_CR : CH_LF, 1'b0);
        repeat ($urandom_range(1, 4))
        begin
            repeat ($urandom_range(1, 6))
            begin
                k = BYTE_W'($urandom_range(255));
                if (k == CH_CR || k == CH_LF || k == CH_COLON)
                    k = 8'h6B;
                push_item(k, 1'b0);
            end
            push_item(CH_COLON, 1'b0);
            push_item(CH_SPACE, 1'b0);
            sel = $urandom_range(9);
            if (sel == 0)
                vlen = 0;
            else if (sel == 1 && eff <= 40)
                vlen = eff + 1;
            else if (sel == 2 && eff <= 40)
                vlen = eff;
            else
                vlen = $urandom_range(1, (eff < 12) ? eff : 12);
            repeat (vlen)
                push_item(value_byte(), 1'b0);
            push_item(CH_CR, 1'b0);
            push_item(CH_LF, 1'b0);
        end
        push_item(CH_CR, 1'b0);
        push_item(CH_LF, 1'b0);
        repeat ($urandom_range(3))
            push_item(BYTE_W'($urandom_range(255)), 1'b0);
        if ($urandom_range(7) != 0)
        begin
            tmp = byte_q[start];
            tmp.restart = 1'b1;
            byte_q[start] = tmp;
        end
        if (corrupt)
        begin
            idx = start + $urandom_range(byte_q.size() - start - 1);
            tmp = byte_q[idx];
            tmp.data_byte = pick_special();
            byte_q[idx] = tmp;
        end
    endfunction

    function automatic void gen_traffic(input int n);
        int target;
        target = pushed + n;
        while (pushed < target)
        begin
            case ($urandom_range(9))
                7: gen_message(1'b1);
                8: repeat ($urandom_range(1, 8)) push_item(pick_special(), 1'b0);
                9: push_item(pick_special(), 1'b1);
                default: gen_message(1'b0);
            endcase
        end
    endfunction

    task automatic apb_xfer(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_MAX_VALUE_LEN, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        if (wr)
            cfg_len = wdata[LEN_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_max_len(input int v);
        logic [31:0] rd;
        apb_xfer(1'b1, v, rd);
        apb_xfer(1'b0, '0, rd);
        if (rd[LEN_W-1:0] !== v[LEN_W-1:0])
            report_mismatch($sformatf("max_value_len read %0d want %0d", rd[LEN_W-1:0], v));
    endtask

    // Block is idle once nothing is queued, offered or outstanding.
    task automatic wait_idle();
        do @(posedge clk); while (byte_q.size() != 0 || in_valid || tag_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // driver
    always @(negedge clk)
    begin : drv
        hhp_item_t cur;
        if (!in_valid || in_taken)
        begin
            if (byte_q.size() != 0 && $urandom_range(99) >= snd_pct)
            begin
                cur = byte_q.pop_front();
                in_valid  <= 1'b1;
                data_byte <= cur.data_byte;
                restart   <= cur.restart;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver ready, with an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= rcv_pct);
        end
    end

    // monitor: predict on each input transaction, check each output transaction
    always @(posedge clk)
    begin : mon
        hhp_item_t   it;
        hhp_result_t e;
        in_taken <= in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                it.data_byte = data_byte;
                it.restart = restart;
                tag_q.push_back(parse_byte(it));
            end
            if (out_valid && out_ready)
            begin
                if (tag_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result byte %0h role %0d",
                                              out_byte, role));
                end
                else
                begin
                    e = tag_q.pop_front();
                    if (out_byte !== e.out_byte)
                        report_mismatch($sformatf("out_byte %0h want %0h",
                                                  out_byte, e.out_byte));
                    if (role !== e.role)
                        report_mismatch($sformatf("role %0d want %0d byte %0h",
                                                  role, e.role, e.out_byte));
                    if (error_cause !== e.error_cause)
                        report_mismatch($sformatf("error_cause %0d want %0d byte %0h",
                                                  error_cause, e.error_cause, e.out_byte));
                    if (value_length !== e.value_length)
                        report_mismatch($sformatf("value_length %0d want %0d byte %0h",
                                                  value_length, e.value_length, e.out_byte));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("FAIL http_header_byte_parser");
            $finish;
        end
    end

    initial
    begin : stim
        logic [31:0] rd;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        apb_xfer(1'b0, '0, rd);
        if (rd[LEN_W-1:0] !== MAX_VALUE_LEN_RST)
            report_mismatch($sformatf("max_value_len reset %0d", rd[LEN_W-1:0]));

        snd_pct = 8;
        rcv_pct = 80;
        // leading CR/LF skipped, colon as first key byte, CR as first value byte
        push_item(CH_CR, 1'b1);  push_item(CH_LF, 1'b0);  push_item(CH_COLON, 1'b0);
        push_item(8'h61, 1'b0);  push_item(CH_COLON, 1'b0); push_item(CH_SPACE, 1'b0);
        push_item(CH_CR, 1'b0);  push_item(8'h78, 1'b0);  push_item(CH_CR, 1'b0);
        push_item(CH_LF, 1'b0);
        // LF right after a line LF starts a new key
        push_item(CH_LF, 1'b0);  push_item(CH_COLON, 1'b0); push_item(CH_SPACE, 1'b0);
        push_item(8'h76, 1'b0);  push_item(CH_CR, 1'b0);  push_item(CH_LF, 1'b0);
        push_item(CH_CR, 1'b0);  push_item(CH_LF, 1'b0);
        push_item(8'h00, 1'b0);  push_item(8'hFF, 1'b0);
        // LF in key, sticky error, then missing space
        push_item(8'h6B, 1'b1);  push_item(CH_LF, 1'b0);  push_item(8'h7A, 1'b0);
        push_item(8'h6B, 1'b1);  push_item(CH_COLON, 1'b0); push_item(8'h21, 1'b0);

        wait_idle();
        set_max_len(1);
        gen_traffic(60);

        wait_idle();
        snd_pct = 80;
        rcv_pct = 8;
        set_max_len(0);   // behaves as a limit of one
        gen_traffic(50);

        // value runs up to a count of 1024, then one byte too many
        wait_idle();
        set_max_len(1024);
        push_item(8'h4D, 1'b1);
        push_item(CH_COLON, 1'b0);
        push_item(CH_SPACE, 1'b0);
        repeat (1025) push_item(value_byte(), 1'b0);
        push_item(CH_CR, 1'b0);
        push_item(CH_LF, 1'b0);
        gen_traffic(40);

        wait_idle();
        snd_pct = 0;
        rcv_pct = 0;
        set_max_len($urandom_range(2, 40));
        gen_traffic(100);
        hold_req <= hold_req + 1;

        wait_idle();
        set_max_len($urandom_range(41, 300));
        gen_traffic(50);

        wait_idle();
        repeat (10) @(posedge clk);
        if (err_cnt == 0)
            $display("PASS http_header_byte_parser");
        else
            $display("FAIL http_header_byte_parser");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/hhp_pkg.sv
sv/hhp_apb_regs.sv
sv/hhp_parse_core.sv
sv/http_header_byte_parser.sv
tb/tb_http_header_byte_parser.sv
